@@ rtl/esa_pkg.sv @@
// Shared constants, types and command/status bundles for the encoder speed estimator.
package esa_pkg;

  // Encoder geometry and speed scaling
  localparam int ENC_COUNTS    = 4096;
  localparam int POS_W         = 12;
  localparam int HALF_TURN     = ENC_COUNTS / 2;
  localparam int RPM_SCALE_Q8  = 153600000;
  localparam int RPM_PER_COUNT = RPM_SCALE_Q8 / ENC_COUNTS;

  // Field widths
  localparam int TICK_W   = 32;
  localparam int MS_W     = 32;
  localparam int SPEED_W  = 28;
  localparam int OFFSET_W = 18;
  localparam int PP_W     = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // Shared divider geometry
  localparam int DIV_NUM_W = 61;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_QUO_W = 29;

  // Stream widths
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_TIME = 2'd3;

  // Register reset values
  localparam logic [PP_W-1:0]  RST_POLE_PAIRS = 7'd7;
  localparam logic [CFG_W-1:0] RST_MIN_TICKS  = 16'd50;
  localparam logic [CFG_W-1:0] RST_TAU_TICKS  = 16'd500;
  localparam logic [CFG_W-1:0] RST_ALIGN_TIME = 16'd500;

  // Control modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_ALIGN  = 2'd1;
  localparam logic [1:0] MODE_CLOSED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_D1_GO,
    ST_D1_WAIT,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_D2_GO,
    ST_D2_WAIT,
    ST_FIN,
    ST_EMIT
  } esa_state_t;

  typedef struct packed {
    logic [PP_W-1:0]  pole_pairs;
    logic [CFG_W-1:0] min_ticks;
    logic [CFG_W-1:0] tau_ticks;
    logic [CFG_W-1:0] align_time;
  } esa_cfg_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_go;
    logic diff;
    logic mul;
    logic add;
    logic fin;
    logic emit;
  } esa_cmd_t;

  typedef struct packed {
    logic sample_go;
    logic div_busy;
  } esa_sts_t;

endpackage

@@ rtl/esa_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient width known in advance.
module esa_div #(
  parameter int NUM_W = esa_pkg::DIV_NUM_W,
  parameter int DEN_W = esa_pkg::DIV_DEN_W,
  parameter int QUO_W = esa_pkg::DIV_QUO_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] bits_r, bits_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // Trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_r, bits_r[QUO_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // Load on start, then shift one bit a cycle
  always_comb begin
    rem_nxt  = rem_r;
    bits_nxt = bits_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = DEN_W'(num >> QUO_W);
      bits_nxt = num[QUO_W-1:0];
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      bits_nxt = {bits_r[QUO_W-2:0], 1'b0};
      quo_nxt  = {quo_r[QUO_W-2:0], fits};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    quo_r  <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

@@ rtl/esa_dp.sv @@
// Datapath: input capture, mode state, speed arithmetic, filter and output register.
module esa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  esa_pkg::esa_cfg_t                 cfg,
  input  esa_pkg::esa_cmd_t                 cmd,
  output esa_pkg::esa_sts_t                 sts,
  input  logic [esa_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [esa_pkg::IN_USER_W-1:0]     in_tuser,
  output logic [esa_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [esa_pkg::OUT_USER_W-1:0]    out_tuser
);
  import esa_pkg::*;

  localparam int DLT_W = POS_W + 2;
  localparam int MAG_W = POS_W + 1;
  localparam int M_W   = MAG_W + 16;
  localparam int RAW_W = SPEED_W + 2;
  localparam int PRD_W = SPEED_W + TICK_W;
  localparam int OFF_W = OFFSET_W + 1;

  localparam logic signed [DLT_W-1:0] HALF_S = DLT_W'(HALF_TURN);
  localparam logic signed [DLT_W-1:0] TURN_S = DLT_W'(ENC_COUNTS);

  // Captured item
  logic [TICK_W-1:0] tick_r;
  logic [POS_W-1:0]  pos_r;
  logic [MS_W-1:0]   ms_r;
  logic              start_r;
  logic              stop_r;

  // Architectural state
  logic [TICK_W-1:0]        prev_tick_r;
  logic [POS_W-1:0]         prev_pos_r;
  logic signed [SPEED_W-1:0] filt_r;
  logic [1:0]               mode_r;
  logic [MS_W-1:0]          align_start_r;
  logic [OFFSET_W-1:0]      offset_r;
  logic                     run_r;
  logic                     sample_r;
  logic                     pulse_r;

  // Working registers
  logic [TICK_W-1:0]    dt_r;
  logic                 rneg_r;
  logic                 dneg_r;
  logic [SPEED_W-1:0]   dmag_r;
  logic [PRD_W-1:0]     prod_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;

  // Output register
  logic                 o_sample_r;
  logic [SPEED_W-1:0]   o_speed_r;
  logic [1:0]           o_mode_r;
  logic                 o_run_r;
  logic [OFFSET_W-1:0]  o_offset_r;
  logic                 o_pulse_r;

  logic [DIV_QUO_W-1:0] quo;
  logic                 div_busy;

  logic [TICK_W-1:0]        dt;
  logic [CFG_W-1:0]         min_dt;
  logic                     sample_go;
  logic signed [DLT_W-1:0]  delta0;
  logic signed [DLT_W-1:0]  delta;
  logic [DLT_W-1:0]         dabs;
  logic [MAG_W-1:0]         dmag;
  logic [M_W-1:0]           mscaled;
  logic signed [RAW_W-1:0]  qs;
  logic signed [RAW_W-1:0]  raw;
  logic signed [RAW_W-1:0]  diff;
  logic [RAW_W-1:0]         diff_abs;
  logic signed [RAW_W-1:0]  stepv;
  logic signed [RAW_W-1:0]  filt_sum;
  logic [MS_W-1:0]          align_el;
  logic                     align_done;
  logic [OFF_W-1:0]         off_full;

  // Sample spacing check
  always_comb begin
    dt        = tick_r - prev_tick_r;
    min_dt    = (cfg.min_ticks == '0) ? CFG_W'(1) : cfg.min_ticks;
    sample_go = dt >= TICK_W'(min_dt);
  end

  // Position delta wrapped to half a turn, scaled to the raw speed numerator
  always_comb begin
    delta0 = $signed(DLT_W'(pos_r)) - $signed(DLT_W'(prev_pos_r));
    delta  = delta0;
    if (delta0 > HALF_S) begin
      delta = delta0 - TURN_S;
    end else if (delta0 < -HALF_S) begin
      delta = delta0 + TURN_S;
    end
    dabs    = delta[DLT_W-1] ? DLT_W'(-delta) : DLT_W'(delta);
    dmag    = dabs[MAG_W-1:0];
    mscaled = M_W'(dmag) * M_W'(RPM_PER_COUNT);
  end

  // Signed results from the divider magnitude
  always_comb begin
    qs       = $signed(RAW_W'(quo));
    raw      = rneg_r ? -qs : qs;
    diff     = raw - RAW_W'(filt_r);
    diff_abs = diff[RAW_W-1] ? RAW_W'(-diff) : RAW_W'(diff);
    stepv    = dneg_r ? -qs : qs;
    filt_sum = RAW_W'(filt_r) + stepv;
  end

  // Alignment timeout and electrical offset
  always_comb begin
    align_el   = ms_r - align_start_r;
    align_done = (mode_r == MODE_ALIGN) && (align_el >= MS_W'(cfg.align_time));
    off_full   = OFF_W'(pos_r) * OFF_W'(cfg.pole_pairs);
  end

  // Capture the accepted transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick_r  <= in_tdata[31:0];
      pos_r   <= in_tdata[43:32];
      ms_r    <= in_tdata[75:44];
      start_r <= in_tuser[0];
      stop_r  <= in_tuser[1];
    end
  end

  // Architectural state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tick_r   <= '0;
      prev_pos_r    <= '0;
      filt_r        <= '0;
      mode_r        <= MODE_IDLE;
      align_start_r <= '0;
      offset_r      <= '0;
      run_r         <= 1'b0;
      sample_r      <= 1'b0;
      pulse_r       <= 1'b0;
    end else begin
      if (cmd.eval) begin
        if (stop_r) begin
          mode_r <= MODE_IDLE;
          run_r  <= 1'b0;
        end else if (start_r && mode_r == MODE_IDLE) begin
          mode_r        <= MODE_ALIGN;
          align_start_r <= ms_r;
        end
        sample_r <= sample_go;
        pulse_r  <= 1'b0;
        if (sample_go) begin
          prev_tick_r <= tick_r;
          prev_pos_r  <= pos_r;
        end
      end
      if (cmd.fin) begin
        filt_r <= filt_sum[SPEED_W-1:0];
        if (align_done) begin
          offset_r <= off_full[OFFSET_W] ? OFFSET_W'((1 << OFFSET_W) - 1) :
                      off_full[OFFSET_W-1:0];
          pulse_r  <= 1'b1;
          mode_r   <= MODE_CLOSED;
          run_r    <= 1'b1;
        end
      end
    end
  end

  // Working registers for the two divisions
  always_ff @(posedge clk) begin
    if (cmd.eval && sample_go) begin
      dt_r   <= dt;
      rneg_r <= delta[DLT_W-1];
      num_r  <= DIV_NUM_W'({mscaled, 1'b0}) + DIV_NUM_W'(dt);
      den_r  <= DIV_DEN_W'({dt, 1'b0});
    end
    if (cmd.diff) begin
      dneg_r <= diff[RAW_W-1];
      dmag_r <= diff_abs[SPEED_W-1:0];
    end
    if (cmd.mul) begin
      prod_r <= PRD_W'(dmag_r) * PRD_W'(dt_r);
      den_r  <= DIV_DEN_W'(cfg.tau_ticks) + DIV_DEN_W'(dt_r);
    end
    if (cmd.add) begin
      num_r <= DIV_NUM_W'(prod_r) + DIV_NUM_W'(den_r >> 1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_sample_r <= sample_r;
      o_speed_r  <= filt_r;
      o_mode_r   <= mode_r;
      o_run_r    <= run_r;
      o_offset_r <= offset_r;
      o_pulse_r  <= pulse_r;
    end
  end

  esa_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .QUO_W (DIV_QUO_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  assign sts.sample_go = sample_go;
  assign sts.div_busy  = div_busy;

  assign out_tdata = {6'b0, o_pulse_r, o_offset_r, o_run_r, o_mode_r, o_speed_r};
  assign out_tuser = o_sample_r;

endmodule

@@ rtl/esa_cfg.sv @@
// Configuration register file with its write channel.
module esa_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [esa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esa_pkg::CFG_W-1:0]     cfg_data,
  output esa_pkg::esa_cfg_t             cfg
);
  import esa_pkg::*;

  esa_cfg_t regs_r, regs_nxt;

  // Decode the write transfer
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_POLE_PAIRS: regs_nxt.pole_pairs = cfg_data[PP_W-1:0];
        CFG_MIN_TICKS:  regs_nxt.min_ticks  = cfg_data;
        CFG_TAU_TICKS:  regs_nxt.tau_ticks  = cfg_data;
        CFG_ALIGN_TIME: regs_nxt.align_time = cfg_data;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pole_pairs <= RST_POLE_PAIRS;
      regs_r.min_ticks  <= RST_MIN_TICKS;
      regs_r.tau_ticks  <= RST_TAU_TICKS;
      regs_r.align_time <= RST_ALIGN_TIME;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg       = regs_r;

endmodule

@@ rtl/esa_ctrl.sv @@
// Sequencer: steps one item through evaluation, two divisions, filter update and output.
module esa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  esa_pkg::esa_sts_t sts,
  output esa_pkg::esa_cmd_t cmd
);
  import esa_pkg::*;

  esa_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.sample_go ? ST_D1_GO : ST_EMIT;
      end
      ST_D1_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_D1_WAIT;
      end
      ST_D1_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_D2_GO;
      end
      ST_D2_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_D2_WAIT;
      end
      ST_D2_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/encoder_speed_estimator_align.sv @@
// Encoder speed estimator with align/closed-loop sequencing: top level.
// Each input transfer yields exactly one result transfer. An item whose tick
// spacing is below min_ticks is accepted, evaluated and loaded into the
// output register. A sampled item is accepted and evaluated, then starts the
// shared restoring divider twice (29 quotient bits each; raw speed, then
// filter step); between and after the two divisions come the filter
// difference, a 28x32 multiply, the rounding add, filter update and output
// load. Either path waits at output load while the previous result still
// waits in the output register. A new item is accepted whenever the sequencer
// is idle, even while the previous result still waits in the output register.
// Registers may be written only while no item is in work; the configuration
// channel is always ready. After reset mode is idle, speed and offset are zero,
// and the registers hold 7, 50, 500 and 500.
module encoder_speed_estimator_align (
  input  logic                           clk,
  input  logic                           rst_n,
  // tick_count[31:0], encoder_position[43:32], millis[75:44], zero fill
  input  logic [esa_pkg::IN_DATA_W-1:0]  in_tdata,
  // start_cmd[0], stop_cmd[1]
  input  logic [esa_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // speed_rpm_q8[27:0], mode[29:28], running[30], angle_offset[48:31],
  // controller_reset[49], zero fill
  output logic [esa_pkg::OUT_DATA_W-1:0] out_tdata,
  // sample_taken[0]
  output logic [esa_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [esa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esa_pkg::CFG_W-1:0]      cfg_data
);
  import esa_pkg::*;

  esa_cfg_t cfg;
  esa_cmd_t cmd;
  esa_sts_t sts;

  esa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  esa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
